// File: rtl/lut3_pkg.sv
// types, constants and code values shared by the 3d lut color map
// depends on nothing
`timescale 1ns / 1ps

package lut3_pkg;

    localparam int MAX_GRID  = 33;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH     = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COMP_W    = 17;
    localparam int GRID_W    = 6;
    localparam int IDX_W     = 16;
    localparam int ENTRY_W   = 3 * COMP_W;
    localparam int FRAC_W    = COMP_W + GRID_W;
    localparam int GROW_W    = COMP_W + GRID_W - FRAC_BITS + 1;
    localparam int V1_W      = COMP_W + 1 + GROW_W;
    localparam int V2_W      = V1_W + GROW_W;
    localparam int V3_W      = V2_W + GROW_W;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int OUT_TOP   = (ONE_FX < (1 << COMP_W) - 1) ? ONE_FX : (1 << COMP_W) - 1;
    localparam int CFG_DATA_W = GRID_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic REG_BYPASS    = 1'b1;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [COMP_W-1:0] out_red;
        logic [COMP_W-1:0] out_green;
        logic [COMP_W-1:0] out_blue;
    } pix_out_t;

    typedef struct packed {
        logic                         valid;
        logic                         cmd;
        logic [IDX_W-1:0]             idx;
        logic [2:0][COMP_W-1:0]       comp;
        logic [2:0][FRAC_W-1:0]       frac;
        logic [7:0][ADDR_W-1:0]       addr;
    } addr_req_t;

    typedef struct packed {
        logic                         valid;
        logic                         cmd;
        logic [2:0][COMP_W-1:0]       comp;
        logic [2:0][FRAC_W-1:0]       frac;
    } blend_in_t;

    typedef struct packed {
        logic                         valid;
        logic                         cmd;
        logic [2:0][COMP_W-1:0]       comp;
        logic [2:0][V3_W-1:0]         val;
    } blend_out_t;

endpackage

// File: rtl/lut3_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module lut3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lut3_addr.sv
// input register, lattice coordinate scaling and corner address stages
// depends on lut3_pkg
`timescale 1ns / 1ps

module lut3_addr (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  lut3_pkg::pix_in_t          in_data,
    input  logic [lut3_pkg::GRID_W-1:0] grid,
    output lut3_pkg::addr_req_t        req
);

    localparam int GW = lut3_pkg::GRID_W;
    localparam int CW = lut3_pkg::COMP_W;
    localparam int FW = lut3_pkg::FRAC_W;
    localparam int FB = lut3_pkg::FRAC_BITS;
    localparam int AW = lut3_pkg::ADDR_W;
    localparam int BW = FW - FB;

    // stage 1
    logic              v1_reg;
    lut3_pkg::pix_in_t d1_reg;

    // stage 2
    logic                   v2_reg;
    logic                   cmd2_reg;
    logic [lut3_pkg::IDX_W-1:0] idx2_reg;
    logic [2:0][CW-1:0]     comp2_reg;
    logic [2:0][GW-1:0]     base2_reg, base2_next;
    logic [2:0][FW-1:0]     frac2_reg, frac2_next;

    // stage 3
    lut3_pkg::addr_req_t    req_reg, req_next;

    logic [GW-1:0]          nsat;
    logic [2*GW-1:0]        nn_reg;
    logic [2:0][CW-1:0]     comp1;
    logic [FW-1:0]          coord [3];
    logic [BW-1:0]          cbase [3];
    logic [1:0][3*GW-1:0]   gn;
    logic [1:0][3*GW-1:0]   bnn;
    logic [GW-1:0]          ri [2];
    logic [3*GW-1:0]        asum [8];

    always_comb begin
        if (grid < GW'(2)) begin
            nsat = GW'(2);
        end else if (grid > GW'(lut3_pkg::MAX_GRID)) begin
            nsat = GW'(lut3_pkg::MAX_GRID);
        end else begin
            nsat = grid;
        end
    end

    assign comp1 = {d1_reg.red, d1_reg.green, d1_reg.blue};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coord[k] = FW'(comp1[2-k]) * FW'(nsat - GW'(1));
            cbase[k] = coord[k][FW-1:FB];
            if (cbase[k] > BW'(nsat - GW'(2))) begin
                base2_next[k] = nsat - GW'(2);
            end else begin
                base2_next[k] = cbase[k][GW-1:0];
            end
            frac2_next[k] = coord[k] - FW'({base2_next[k], FB'(0)});
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            ri[j]  = base2_reg[0] + GW'(j);
            gn[j]  = (3*GW)'(base2_reg[1] + GW'(j)) * (3*GW)'(nsat);
            bnn[j] = (3*GW)'(base2_reg[2] + GW'(j)) * (3*GW)'(nn_reg);
        end
        for (int k = 0; k < 8; k++) begin
            asum[k] = (3*GW)'(ri[(k >> 2) & 1]) + gn[(k >> 1) & 1] + bnn[k & 1];
        end
        req_next.valid = v2_reg;
        req_next.cmd   = cmd2_reg;
        req_next.idx   = idx2_reg;
        req_next.comp  = comp2_reg;
        req_next.frac  = frac2_reg;
        for (int k = 0; k < 8; k++) begin
            req_next.addr[k] = asum[k][AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        nn_reg <= (2*GW)'(nsat) * (2*GW)'(nsat);
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            req_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            req_reg.valid <= req_next.valid;
        end
        if (en) begin
            d1_reg    <= in_data;
            cmd2_reg  <= d1_reg.command;
            idx2_reg  <= d1_reg.entry_index;
            comp2_reg <= {comp1[0], comp1[1], comp1[2]};
            base2_reg <= base2_next;
            frac2_reg <= frac2_next;
            req_reg.cmd  <= req_next.cmd;
            req_reg.idx  <= req_next.idx;
            req_reg.comp <= req_next.comp;
            req_reg.frac <= req_next.frac;
            req_reg.addr <= req_next.addr;
        end
    end

    assign req = req_reg;

endmodule

// File: rtl/lut3_blend.sv
// three trilinear blend stages: along blue, then green, then red
// depends on lut3_pkg
`timescale 1ns / 1ps

module lut3_blend (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  lut3_pkg::blend_in_t                   bin,
    input  logic [7:0][lut3_pkg::ENTRY_W-1:0]     corner,
    output lut3_pkg::blend_out_t                  bout
);

    localparam int CW  = lut3_pkg::COMP_W;
    localparam int FW  = lut3_pkg::FRAC_W;
    localparam int FB  = lut3_pkg::FRAC_BITS;
    localparam int W1  = lut3_pkg::V1_W;
    localparam int W2  = lut3_pkg::V2_W;
    localparam int W3  = lut3_pkg::V3_W;
    localparam int P1  = CW + 2 + FW + 2;
    localparam int P2  = W1 + 1 + FW + 2;
    localparam int P3  = W2 + 1 + FW + 2;

    // stage 5: blue blend
    logic                v5_reg, cmd5_reg;
    logic [2:0][CW-1:0]  comp5_reg;
    logic [FW-1:0]       fy5_reg, fx5_reg;
    logic signed [W1-1:0] z_reg [3][4];
    logic signed [W1-1:0] z_next [3][4];

    // stage 6: green blend
    logic                v6_reg, cmd6_reg;
    logic [2:0][CW-1:0]  comp6_reg;
    logic [FW-1:0]       fx6_reg;
    logic signed [W2-1:0] y_reg [3][2];
    logic signed [W2-1:0] y_next [3][2];

    // stage 7: red blend
    logic                v7_reg, cmd7_reg;
    logic [2:0][CW-1:0]  comp7_reg;
    logic signed [W3-1:0] x_reg [3];
    logic signed [W3-1:0] x_next [3];

    logic signed [CW:0]   za, zb;
    logic signed [CW+1:0] zd;
    logic signed [P1-1:0] zacc;
    logic signed [W1:0]   yd;
    logic signed [P2-1:0] yacc;
    logic signed [W2:0]   xd;
    logic signed [P3-1:0] xacc;
    logic signed [FW:0]   fz, fy, fx;

    always_comb begin
        fz = signed'({1'b0, bin.frac[2]});
        for (int c = 0; c < 3; c++) begin
            for (int p = 0; p < 4; p++) begin
                za = signed'({1'b0, corner[2*p][(2-c)*CW +: CW]});
                zb = signed'({1'b0, corner[2*p+1][(2-c)*CW +: CW]});
                zd = zb - za;
                zacc = P1'(zd) * P1'(fz) + (P1'(za) <<< FB) + P1'(1 << (FB - 1));
                z_next[c][p] = W1'(zacc >>> FB);
            end
        end
    end

    always_comb begin
        fy = signed'({1'b0, fy5_reg});
        for (int c = 0; c < 3; c++) begin
            for (int p = 0; p < 2; p++) begin
                yd = W1'(0) + z_reg[c][2*p+1];
                yd = yd - z_reg[c][2*p];
                yacc = P2'(yd) * P2'(fy) + (P2'(z_reg[c][2*p]) <<< FB)
                     + P2'(1 << (FB - 1));
                y_next[c][p] = W2'(yacc >>> FB);
            end
        end
    end

    always_comb begin
        fx = signed'({1'b0, fx6_reg});
        for (int c = 0; c < 3; c++) begin
            xd = W2'(0) + y_reg[c][1];
            xd = xd - y_reg[c][0];
            xacc = P3'(xd) * P3'(fx) + (P3'(y_reg[c][0]) <<< FB) + P3'(1 << (FB - 1));
            x_next[c] = W3'(xacc >>> FB);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= bin.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
        if (en) begin
            cmd5_reg  <= bin.cmd;
            comp5_reg <= bin.comp;
            fy5_reg   <= bin.frac[1];
            fx5_reg   <= bin.frac[0];
            z_reg     <= z_next;
            cmd6_reg  <= cmd5_reg;
            comp6_reg <= comp5_reg;
            fx6_reg   <= fx5_reg;
            y_reg     <= y_next;
            cmd7_reg  <= cmd6_reg;
            comp7_reg <= comp6_reg;
            x_reg     <= x_next;
        end
    end

    always_comb begin
        bout.valid = v7_reg;
        bout.cmd   = cmd7_reg;
        bout.comp  = comp7_reg;
        for (int c = 0; c < 3; c++) begin
            bout.val[c] = x_reg[c];
        end
    end

endmodule

// File: rtl/lut3d_trilinear_color_map_top.sv
// top level of the 3d lut color map: config registers, lattice banks, output stage
// depends on lut3_pkg, lut3_ram, lut3_addr, lut3_blend
`timescale 1ns / 1ps

// Color grading 3D LUT with trilinear interpolation, one beat per clock.
// s_ channel carries either a lattice write (command 0: entry_index and
// the entry's red, green, blue) or a pixel (command 1). Each pixel beat
// gives one m_ beat; write beats give none.
// cfg_we/cfg_index/cfg_data set grid_size (index 0) and bypass (index 1);
// write them only while nothing is in flight.
// Pipeline stages from input beat to output valid: input register,
// scale, address, lattice read, three blend stages, output register.
// Throughput: one beat per cycle unless m_ready stalls; the eight lattice
// corners come from eight copies of the lattice, each written by every
// in-range write beat and each read at one corner address, so all corners
// are read in the same cycle; those read ports set the rate, one pixel per cycle.
// Reset clears all valid bits and sets grid_size to 33 and bypass on;
// lattice contents are undefined until written.
// When m_ready is low with a beat waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
module lut3d_trilinear_color_map_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lut3_pkg::pix_in_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lut3_pkg::pix_out_t                 m_data,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [lut3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = lut3_pkg::COMP_W;
    localparam int AW = lut3_pkg::ADDR_W;
    localparam int W3 = lut3_pkg::V3_W;
    localparam int GW = lut3_pkg::GRID_W;
    localparam int IW = lut3_pkg::IDX_W;

    logic [lut3_pkg::GRID_W-1:0] grid_reg;
    logic                        bypass_reg;
    logic                        en;
    logic                        m_valid_reg;
    lut3_pkg::pix_out_t          m_data_reg, m_data_next;

    lut3_pkg::addr_req_t         req;
    lut3_pkg::blend_in_t         bin_reg;
    lut3_pkg::blend_out_t        bout;
    logic [7:0][lut3_pkg::ENTRY_W-1:0] corner;
    logic                        ram_we, ram_re;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg   <= GW'(lut3_pkg::MAX_GRID);
            bypass_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lut3_pkg::REG_GRID_SIZE: grid_reg   <= cfg_data;
                lut3_pkg::REG_BYPASS:    bypass_reg <= cfg_data[0];
            endcase
        end
    end

    lut3_addr u_addr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && s_ready),
        .in_data  (s_data),
        .grid     (grid_reg),
        .req      (req)
    );

    assign ram_we = en && req.valid && (req.cmd == lut3_pkg::CMD_WRITE)
                  && (req.idx < IW'(lut3_pkg::DEPTH));
    assign ram_re = en && req.valid && (req.cmd == lut3_pkg::CMD_PIXEL);

    for (genvar k = 0; k < 8; k++) begin : g_bank
        lut3_ram #(
            .WIDTH (lut3_pkg::ENTRY_W),
            .DEPTH (lut3_pkg::DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (req.idx[AW-1:0]),
            .wdata ({req.comp[0], req.comp[1], req.comp[2]}),
            .re    (ram_re),
            .raddr (req.addr[k]),
            .rdata (corner[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg.valid <= 1'b0;
        end else if (en) begin
            bin_reg.valid <= req.valid;
        end
        if (en) begin
            bin_reg.cmd  <= req.cmd;
            bin_reg.comp <= req.comp;
            bin_reg.frac <= req.frac;
        end
    end

    lut3_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .bin     (bin_reg),
        .corner  (corner),
        .bout    (bout)
    );

    function automatic logic [CW-1:0] clamp_out(input logic signed [W3-1:0] v);
        logic [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > W3'(lut3_pkg::OUT_TOP)) begin
            r = CW'(lut3_pkg::OUT_TOP);
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // comp index 0 is red, 2 is blue
    always_comb begin
        if (bypass_reg) begin
            m_data_next.out_red   = bout.comp[0];
            m_data_next.out_green = bout.comp[1];
            m_data_next.out_blue  = bout.comp[2];
        end else begin
            m_data_next.out_red   = clamp_out(bout.val[0]);
            m_data_next.out_green = clamp_out(bout.val[1]);
            m_data_next.out_blue  = clamp_out(bout.val[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= bout.valid && (bout.cmd == lut3_pkg::CMD_PIXEL);
        end
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a lattice write and a corner read never come from the same beat
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_we && ram_re))
        else $error("lattice write and read in one cycle");

    // corner addresses 0 and 7, the lowest and highest, stay inside the lattice
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> (req.addr[0] < AW'(lut3_pkg::DEPTH)) && (req.addr[7] < AW'(lut3_pkg::DEPTH)))
        else $error("corner address beyond lattice");

    // a held output beat freezes the blend pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(bout.valid) && $stable(bin_reg.valid))
        else $error("pipeline moved during stall");

endmodule

// File: tb/tb.sv
// testbench for lut3d_trilinear_color_map_top: bypass, lattice loads and
// trilinear pixel mapping checked beat by beat against an in-bench predictor
// depends on lut3_pkg and the rtl of lut3d_trilinear_color_map_top
`timescale 1ns / 1ps

class lattice_scoreboard;
    bit [lut3_pkg::COMP_W-1:0] lattice [lut3_pkg::DEPTH][3];
    int unsigned grid_cfg = 33;
    bit bypass_cfg = 1'b1;
    lut3_pkg::pix_out_t expected_colors[$];
    int errors = 0;

    function longint blend(longint a, longint b, longint f);
        longint acc;
        acc = a * (longint'(lut3_pkg::ONE_FX) - f) + b * f
            + longint'(lut3_pkg::ONE_FX / 2);
        return acc >>> lut3_pkg::FRAC_BITS;
    endfunction

    function lut3_pkg::pix_out_t map_pixel(lut3_pkg::pix_in_t p);
        lut3_pkg::pix_out_t res;
        bit [lut3_pkg::COMP_W-1:0] comp [3];
        longint coord, base [3], frac [3], corner [8], c00, c01, c10, c11, c0, c1, v;
        longint n, ri, gi, bi, top;
        comp[0] = p.red;
        comp[1] = p.green;
        comp[2] = p.blue;
        if (bypass_cfg) begin
            res.out_red = p.red;
            res.out_green = p.green;
            res.out_blue = p.blue;
            return res;
        end
        n = (grid_cfg < 2) ? 2 : (grid_cfg > lut3_pkg::MAX_GRID) ? lut3_pkg::MAX_GRID : grid_cfg;
        top = lut3_pkg::OUT_TOP;
        for (int k = 0; k < 3; k++) begin
            coord = longint'(comp[k]) * (n - 1);
            base[k] = coord >>> lut3_pkg::FRAC_BITS;
            if (base[k] > n - 2) base[k] = n - 2;
            frac[k] = coord - (base[k] <<< lut3_pkg::FRAC_BITS);
        end
        for (int ch = 0; ch < 3; ch++) begin
            // corner bit 2 red, bit 1 green, bit 0 blue
            for (int k = 0; k < 8; k++) begin
                ri = base[0] + ((k >> 2) & 1);
                gi = base[1] + ((k >> 1) & 1);
                bi = base[2] + (k & 1);
                corner[k] = lattice[ri + gi * n + bi * n * n][ch];
            end
            c00 = blend(corner[0], corner[1], frac[2]);
            c01 = blend(corner[2], corner[3], frac[2]);
            c10 = blend(corner[4], corner[5], frac[2]);
            c11 = blend(corner[6], corner[7], frac[2]);
            c0 = blend(c00, c01, frac[1]);
            c1 = blend(c10, c11, frac[1]);
            v = blend(c0, c1, frac[0]);
            if (v < 0) v = 0;
            if (v > top) v = top;
            case (ch)
                0: res.out_red = v[lut3_pkg::COMP_W-1:0];
                1: res.out_green = v[lut3_pkg::COMP_W-1:0];
                default: res.out_blue = v[lut3_pkg::COMP_W-1:0];
            endcase
        end
        return res;
    endfunction

    function void note_beat(lut3_pkg::pix_in_t p);
        if (p.command == lut3_pkg::CMD_WRITE) begin
            if (p.entry_index < lut3_pkg::DEPTH) begin
                lattice[p.entry_index][0] = p.red;
                lattice[p.entry_index][1] = p.green;
                lattice[p.entry_index][2] = p.blue;
            end
        end else begin
            expected_colors = {expected_colors, map_pixel(p)};
        end
    endfunction

    function void check_result(lut3_pkg::pix_out_t got);
        lut3_pkg::pix_out_t exp_c;
        if (expected_colors.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
        end
        exp_c = expected_colors.pop_front();
        if (got.out_red !== exp_c.out_red) begin
            $error("out_red expected %0d actual %0d", exp_c.out_red, got.out_red);
            errors++;
        end
        if (got.out_green !== exp_c.out_green) begin
            $error("out_green expected %0d actual %0d", exp_c.out_green, got.out_green);
            errors++;
        end
        if (got.out_blue !== exp_c.out_blue) begin
            $error("out_blue expected %0d actual %0d", exp_c.out_blue, got.out_blue);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CW = lut3_pkg::COMP_W;
    localparam int IW = lut3_pkg::IDX_W;
    localparam int DW = lut3_pkg::CFG_DATA_W;
    localparam bit [CW-1:0] CMAX = '1;
    localparam bit [CW-1:0] ONE = CW'(lut3_pkg::ONE_FX);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lut3_pkg::pix_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lut3_pkg::pix_out_t m_data;
    logic cfg_we = 1'b0;
    logic cfg_index = lut3_pkg::REG_GRID_SIZE;
    logic [DW-1:0] cfg_data = '0;

    lattice_scoreboard sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_count = 0;
    bit filled [lut3_pkg::MAX_GRID+1];

    lut3d_trilinear_color_map_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_beat(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver stall pattern, with stretches of no stall
    always @(posedge aclk) begin
        if (stall_count == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(20, 300);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        #2_000_000;
        $display("lut3d_trilinear_color_map_top regression: fail");
        $finish;
    end

    task automatic send_beat(input lut3_pkg::pix_in_t b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_write(input int idx);
        lut3_pkg::pix_in_t b;
        b.command = lut3_pkg::CMD_WRITE;
        b.entry_index = IW'(idx);
        b.red = CW'($urandom);
        b.green = CW'($urandom);
        b.blue = CW'($urandom);
        send_beat(b);
    endtask

    function automatic bit [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return CW'($urandom);
            1: return CMAX - CW'($urandom_range(0, 3));
            2: return ONE - CW'($urandom_range(0, 2));
            3: return CW'($urandom_range(0, 3));
            default: return CW'($urandom_range(0, lut3_pkg::ONE_FX));
        endcase
    endfunction

    // component whose base corner along its axis is cell b
    function automatic bit [CW-1:0] comp_in_cell(input int n, input int b);
        int lo, hi;
        lo = (b * lut3_pkg::ONE_FX + n - 2) / (n - 1);
        if (b == n - 2) hi = (1 << CW) - 1;
        else hi = ((b + 1) * lut3_pkg::ONE_FX + n - 2) / (n - 1) - 1;
        return CW'($urandom_range(hi, lo));
    endfunction

    function automatic int cell_pick(input int n);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return n / 2 - 1;
            default: return n - 2;
        endcase
    endfunction

    function automatic bit [CW-1:0] pick_comp(input int n, input bit sparse);
        if (sparse) return comp_in_cell(n, cell_pick(n));
        return rand_comp();
    endfunction

    task automatic send_pixel(input bit [CW-1:0] r, g, b);
        lut3_pkg::pix_in_t p;
        p.command = lut3_pkg::CMD_PIXEL;
        p.entry_index = IW'($urandom);
        p.red = r;
        p.green = g;
        p.blue = b;
        send_beat(p);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.expected_colors.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_reg(input logic idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DW'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == lut3_pkg::REG_GRID_SIZE) sb.grid_cfg = value & 'h3F;
        else sb.bypass_cfg = value[0];
        @(posedge aclk);
    endtask

    function automatic int eff_grid(input int v);
        return (v < 2) ? 2 : (v > lut3_pkg::MAX_GRID) ? lut3_pkg::MAX_GRID : v;
    endfunction

    // a full lattice for n so that no pixel reads an entry never written
    task automatic fill_lattice(input int n);
        for (int i = 0; i < n * n * n; i++) send_write(i);
        filled[n] = 1'b1;
    endtask

    // lattice points per axis around the bottom, middle and top cells
    function automatic int lattice_axis(input int n, input int j);
        case (j)
            0: return 0;
            1: return 1;
            2: return n / 2 - 1;
            3: return n / 2;
            4: return n - 2;
            default: return n - 1;
        endcase
    endfunction

    // only the corners of the cells that cell_pick can choose
    task automatic fill_sparse(input int n);
        for (int b = 0; b < 6; b++)
            for (int g = 0; g < 6; g++)
                for (int r = 0; r < 6; r++)
                    send_write(lattice_axis(n, r) + lattice_axis(n, g) * n
                               + lattice_axis(n, b) * n * n);
    endtask

    initial begin
        int gv, n;
        bit sparse;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bypass after reset, writes give no beat
        send_pixel(0, 0, 0);
        send_pixel(CMAX, CMAX, CMAX);
        send_pixel(ONE, 1, ONE / 2);
        send_write(lut3_pkg::DEPTH);
        send_write(16'hFFFF);
        send_pixel(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_idle();

        // grid_size 0 saturates to 2
        set_reg(lut3_pkg::REG_GRID_SIZE, 0);
        set_reg(lut3_pkg::REG_BYPASS, 0);
        fill_lattice(2);
        send_pixel(0, 0, 0);
        send_pixel(ONE, ONE, ONE);
        send_pixel(CMAX, CMAX, CMAX);
        send_pixel(ONE / 2, ONE / 2, ONE / 2);
        send_pixel(1, ONE - 1, ONE + 1);
        send_pixel(CMAX, 0, ONE);
        wait_idle();
        set_reg(lut3_pkg::REG_GRID_SIZE, 1);
        send_pixel(ONE / 4, CW'(3 * lut3_pkg::ONE_FX / 4), ONE / 3);
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                3: gv = lut3_pkg::MAX_GRID;
                7: gv = 63;
                9: gv = 1;
                default: gv = $urandom_range(2, 5);
            endcase
            n = eff_grid(gv);
            set_reg(lut3_pkg::REG_GRID_SIZE, gv);
            set_reg(lut3_pkg::REG_BYPASS, (ph % 5 == 4) ? 1 : 0);
            sparse = (n > 7);
            if (sparse) fill_sparse(n);
            else if (!filled[n]) fill_lattice(n);
            for (int i = 0; i < 80; i++) begin
                case ($urandom_range(0, 19))
                    0, 1: send_write($urandom_range(0, n * n * n - 1));
                    2: send_write($urandom_range(lut3_pkg::DEPTH, 65535));
                    default: send_pixel(pick_comp(n, sparse), pick_comp(n, sparse),
                                        pick_comp(n, sparse));
                endcase
            end
            wait_idle();
        end
        set_reg(lut3_pkg::REG_BYPASS, 1);
        set_reg(lut3_pkg::REG_GRID_SIZE, 33);
        for (int i = 0; i < 40; i++) send_pixel(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_idle();

        if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
            $display("lut3d_trilinear_color_map_top regression: pass");
        end else begin
            $display("lut3d_trilinear_color_map_top regression: fail");
        end
        $finish;
    end
endmodule
